// ----- rtl/ffa_pkg.sv -----
// shared types and constants for the first-fit allocator
// no dependencies; imported by ffa_cfg, ffa_engine, first_fit_allocator and the testbench
package ffa_pkg;

    localparam int SIZE_W   = 17;
    localparam int FADDR_W  = 16;
    localparam int RADDR_W  = 16;
    localparam int FAIL_W   = 32;
    localparam int POOL_W   = 17;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [SIZE_W-1:0]  alloc_size;
        logic [FADDR_W-1:0] free_address;
    } ffa_req_t;

    typedef struct packed {
        logic               ok;
        logic [RADDR_W-1:0] address;
        logic [FAIL_W-1:0]  failure_count;
    } ffa_rsp_t;

    typedef struct packed {
        logic              reload;
        logic [POOL_W-1:0] pool_size;
    } ffa_cfg_t;

endpackage

// ----- rtl/ffa_marker_ram.sv -----
// marker table storage: one write port, one read port, registered read data
// no dependencies
module ffa_marker_ram #(
    parameter int DEPTH = 64,
    parameter int DW    = 18,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/ffa_cfg.sv -----
// apb register file: pool_size, capped to the address range
// depends on ffa_pkg
module ffa_cfg
    import ffa_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output ffa_cfg_t    cfg_o
);

    localparam int CW = (ADDR_BITS + 1 > POOL_W) ? ADDR_BITS + 1 : POOL_W;
    localparam logic [CW-1:0] CAP = {{(CW-1){1'b0}}, 1'b1} << ADDR_BITS;
    localparam logic [CW-1:0] RST_RAW = CW'(65536);
    localparam logic [CW-1:0] RST_CAP = (RST_RAW > CAP) ? CAP : RST_RAW;

    logic [POOL_W-1:0] pool_reg;
    logic [POOL_W-1:0] pool_next;
    logic              wr_hit;
    logic [CW-1:0]     wval;

    assign wr_hit = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign wval   = CW'(pwdata[POOL_W-1:0]);

    always_comb begin
        pool_next = pool_reg;
        if (wr_hit) begin
            pool_next = (wval > CAP) ? CAP[POOL_W-1:0] : wval[POOL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= RST_CAP[POOL_W-1:0];
        end else begin
            pool_reg <= pool_next;
        end
    end

    assign prdata          = (paddr[2] == 1'b0) ? 32'(pool_reg) : 32'd0;
    assign cfg_o.reload    = wr_hit;
    assign cfg_o.pool_size = pool_reg;

endmodule

// ----- rtl/ffa_engine.sv -----
// request sequencer: scans, inserts into and compacts the marker table
// depends on ffa_pkg and ffa_marker_ram
module ffa_engine
    import ffa_pkg::*;
#(
    parameter int ADDR_BITS   = 16,
    parameter int MAX_MARKERS = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  ffa_cfg_t cfg_i,
    input  logic     s_valid,
    output logic     s_ready,
    input  ffa_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ffa_rsp_t m_data
);

    localparam int MW  = ADDR_BITS + 1;
    localparam int DW  = MW + 1;
    localparam int CW  = (MW > SIZE_W) ? MW : SIZE_W;
    localparam int IW  = $clog2(MAX_MARKERS + 1);
    localparam int RAW = $clog2(MAX_MARKERS);

    localparam logic [2:0] ST_INIT0 = 3'd0;
    localparam logic [2:0] ST_INIT1 = 3'd1;
    localparam logic [2:0] ST_IDLE  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_INS   = 3'd4;
    localparam logic [2:0] ST_FREE2 = 3'd5;
    localparam logic [2:0] ST_REM   = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic [IW-1:0]     cur_idx_reg, cur_idx_next;
    logic              dval_reg, dval_next;
    logic [IW-1:0]     count_reg, count_next;
    logic [IW-1:0]     ptr_reg, ptr_next;
    ffa_req_t          req_reg, req_next;
    logic [DW-1:0]     prev_reg, prev_next;
    logic [DW-1:0]     carry_reg, carry_next;
    logic              a_reg, a_next;
    logic [1:0]        k_reg, k_next;
    logic              ok_reg, ok_next;
    logic [RADDR_W-1:0] addr_reg, addr_next;
    logic [FAIL_W-1:0] fail_reg, fail_next;
    logic              mv_reg, mv_next;
    ffa_rsp_t          out_reg, out_next;

    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     s_idx;
    logic [IW-1:0]     src0;
    logic              b_flag;
    logic [1:0]        k_calc;
    logic              we;
    logic [IW-1:0]     waddr;
    logic [DW-1:0]     wdata;
    logic [DW-1:0]     rdata;
    logic              d_busy, p_busy;
    logic [CW-1:0]     d_addr, p_addr, seg_len, req_size, new_addr;

    assign d_busy   = rdata[DW-1];
    assign p_busy   = prev_reg[DW-1];
    assign d_addr   = CW'(rdata[MW-1:0]);
    assign p_addr   = CW'(prev_reg[MW-1:0]);
    assign seg_len  = d_addr - p_addr;
    assign req_size = CW'(req_reg.alloc_size);
    assign new_addr = p_addr + req_size;

    // removal window for a free: prev marker if its segment is free, next if free
    assign b_flag = ((ptr_reg + IW'(1)) < count_reg) && !d_busy;
    assign k_calc = {1'b0, a_reg} + {1'b0, b_flag};
    assign s_idx  = a_reg ? (ptr_reg - IW'(1)) : ptr_reg;
    assign src0   = s_idx + IW'(k_calc);

    assign rd_addr = (state_reg == ST_FREE2) ? src0 : rd_idx_reg;

    ffa_marker_ram #(
        .DEPTH (MAX_MARKERS),
        .DW    (DW),
        .AW    (RAW)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr[RAW-1:0]),
        .wdata (wdata),
        .raddr (rd_addr[RAW-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        cur_idx_next = rd_addr;
        dval_next    = 1'b0;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        req_next     = req_reg;
        prev_next    = prev_reg;
        carry_next   = carry_reg;
        a_next       = a_reg;
        k_next       = k_reg;
        ok_next      = ok_reg;
        addr_next    = addr_reg;
        fail_next    = fail_reg;
        mv_next      = mv_reg;
        out_next     = out_reg;
        we           = 1'b0;
        waddr        = ptr_reg;
        wdata        = carry_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_INIT0: begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = {1'b1, {MW{1'b0}}};
                state_next = ST_INIT1;
            end
            ST_INIT1: begin
                we         = 1'b1;
                waddr      = IW'(1);
                wdata      = {1'b0, MW'(cfg_i.pool_size)};
                count_next = IW'(2);
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next    = s_data;
                    rd_idx_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_idx_next = rd_addr + IW'(1);
                dval_next   = 1'b1;
                if (dval_reg) begin
                    if (cur_idx_reg >= count_reg) begin
                        ok_next    = 1'b0;
                        addr_next  = '0;
                        if (req_reg.func == FUNC_ALLOC) begin
                            fail_next = fail_reg + FAIL_W'(1);
                        end
                        state_next = ST_FIN;
                    end else if (cur_idx_reg == '0) begin
                        prev_next = rdata;
                    end else if (req_reg.func == FUNC_ALLOC) begin
                        if (!d_busy && (seg_len >= req_size)) begin
                            if (count_reg >= IW'(MAX_MARKERS)) begin
                                ok_next    = 1'b0;
                                addr_next  = '0;
                                fail_next  = fail_reg + FAIL_W'(1);
                                state_next = ST_FIN;
                            end else begin
                                we         = 1'b1;
                                waddr      = cur_idx_reg;
                                wdata      = {1'b1, new_addr[MW-1:0]};
                                carry_next = rdata;
                                ptr_next   = cur_idx_reg + IW'(1);
                                ok_next    = 1'b1;
                                addr_next  = p_addr[RADDR_W-1:0];
                                state_next = ST_INS;
                            end
                        end else begin
                            prev_next = rdata;
                        end
                    end else begin
                        if ((p_addr == CW'(req_reg.free_address)) && d_busy) begin
                            // mark the segment free in place before any compaction
                            we         = 1'b1;
                            waddr      = cur_idx_reg;
                            wdata      = {1'b0, rdata[MW-1:0]};
                            a_next     = !p_busy;
                            ptr_next   = cur_idx_reg;
                            ok_next    = 1'b1;
                            addr_next  = '0;
                            state_next = ST_FREE2;
                        end else begin
                            prev_next = rdata;
                        end
                    end
                end
            end
            ST_INS: begin
                rd_idx_next = rd_addr + IW'(1);
                dval_next   = 1'b1;
                we          = 1'b1;
                waddr       = ptr_reg;
                wdata       = carry_reg;
                carry_next  = rdata;
                if (ptr_reg == count_reg) begin
                    count_next = count_reg + IW'(1);
                    state_next = ST_FIN;
                end else begin
                    ptr_next = ptr_reg + IW'(1);
                end
            end
            ST_FREE2: begin
                rd_idx_next = rd_addr + IW'(1);
                dval_next   = 1'b1;
                if (k_calc == 2'd0) begin
                    state_next = ST_FIN;
                end else begin
                    ptr_next   = s_idx;
                    k_next     = k_calc;
                    state_next = ST_REM;
                end
            end
            ST_REM: begin
                rd_idx_next = rd_addr + IW'(1);
                dval_next   = 1'b1;
                if (cur_idx_reg >= count_reg) begin
                    count_next = count_reg - IW'(k_reg);
                    state_next = ST_FIN;
                end else begin
                    we       = 1'b1;
                    waddr    = ptr_reg;
                    wdata    = rdata;
                    ptr_next = ptr_reg + IW'(1);
                end
            end
            ST_FIN: begin
                if (!mv_reg || m_ready) begin
                    out_next.ok            = ok_reg;
                    out_next.address       = addr_reg;
                    out_next.failure_count = fail_reg;
                    mv_next                = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_i.reload) begin
            state_next = ST_INIT1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT0;
            dval_reg  <= 1'b0;
            count_reg <= IW'(2);
            fail_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            dval_reg  <= dval_next;
            count_reg <= count_next;
            fail_reg  <= fail_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg  <= rd_idx_next;
        cur_idx_reg <= cur_idx_next;
        ptr_reg     <= ptr_next;
        req_reg     <= req_next;
        prev_reg    <= prev_next;
        carry_reg   <= carry_next;
        a_reg       <= a_next;
        k_reg       <= k_next;
        ok_reg      <= ok_next;
        addr_reg    <= addr_next;
        out_reg     <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= IW'(2)) && (count_reg <= IW'(MAX_MARKERS)))
        else $error("marker count out of range");

    a_entry0_fixed: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && (waddr == '0)) |-> (state_reg == ST_INIT0))
        else $error("marker 0 overwritten");

    a_ins_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS) |-> (ptr_reg <= count_reg))
        else $error("insert shift ran past the table end");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result loaded outside the finish step");

endmodule

// ----- rtl/first_fit_allocator.sv -----
// First-fit allocator with coalescing. The managed range [0, pool_size) is kept
// as an ordered table of boundary markers in a single-port-write, registered-read
// memory of MAX_MARKERS entries; each marker holds an address and a busy bit for the
// segment ending at it. A request is taken only while the sequencer is idle and
// is answered by exactly one result unless a pool_size write reloads the table
// first. Cost per request is set by the table walk, one marker per clock: an
// allocate walks to the first fit and then shifts the tail up; a free walks to its
// segment, checks its neighbors and, when it merges, compacts the table; a miss
// walks the whole table. A finish step and the idle state follow; the finish step
// waits while the previous result is still unaccepted.
// A finished result sits in an output register, so the next request is accepted
// while it waits. Reset (INIT0, INIT1) and every pool_size write (INIT1) reload
// the table; no request is accepted meanwhile. Depends on ffa_pkg, ffa_cfg,
// ffa_engine and ffa_marker_ram.
module first_fit_allocator
    import ffa_pkg::*;
#(
    parameter int ADDR_BITS   = 16,
    parameter int MAX_MARKERS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  ffa_req_t    s_data,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output ffa_rsp_t    m_data
);

    ffa_cfg_t cfg;

    // register writes complete in the access cycle, never stalled
    assign pready = 1'b1;

    // pool_size register with capping and the reload strobe
    ffa_cfg #(
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg_o   (cfg)
    );

    // table walker with the marker memory inside
    ffa_engine #(
        .ADDR_BITS   (ADDR_BITS),
        .MAX_MARKERS (MAX_MARKERS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_i   (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- sim/first_fit_allocator_tb.sv -----
// self-checking testbench for first_fit_allocator: directed table, then random requests
// scored against an in-bench marker-table predictor; depends on rtl/ffa_pkg.sv and the rtl
module first_fit_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;

    localparam int MARKERS   = 64;
    localparam int POOL_MAX  = 65536;
    localparam int SETTLE    = 2 * MARKERS + 16;   // worst-case walk plus margin
    localparam int STALL_MAX = 5000;               // cycles with no handshake at all

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        s_valid, s_ready;
    ffa_req_t    s_data;
    logic        m_valid, m_ready;
    ffa_rsp_t    m_data;

    first_fit_allocator dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------- predictor: copy of the marker table ----------------
    int unsigned mk_addr [MARKERS];
    bit          mk_busy [MARKERS];
    int          mk_count;
    int unsigned pool_units;
    logic [31:0] fails_so_far;

    function automatic void table_reload();
        foreach (mk_addr[k]) begin
            mk_addr[k] = 0;
            mk_busy[k] = 1'b0;
        end
        mk_busy[0] = 1'b1;
        mk_addr[1] = pool_units;
        mk_count   = 2;
    endfunction

    function automatic void drop_marker(int pos);
        for (int k = pos; k < mk_count - 1; k++) begin
            mk_addr[k] = mk_addr[k+1];
            mk_busy[k] = mk_busy[k+1];
        end
        mk_count--;
    endfunction

    // first-fit allocate / coalescing free on the local table
    function automatic ffa_rsp_t predict_alloc_free(ffa_req_t rq);
        ffa_rsp_t    r;
        int unsigned start;
        int          j;
        bit          done;
        r     = '0;
        start = 0;
        done  = 1'b0;
        if (rq.func == FUNC_ALLOC) begin
            for (int i = 1; i < mk_count && !done; i++) begin
                if (mk_busy[i] || (mk_addr[i] - mk_addr[i-1] < rq.alloc_size)) continue;
                done = 1'b1;
                if (mk_count < MARKERS) begin
                    for (int k = mk_count; k > i; k--) begin
                        mk_addr[k] = mk_addr[k-1];
                        mk_busy[k] = mk_busy[k-1];
                    end
                    mk_addr[i] = mk_addr[i-1] + rq.alloc_size;
                    mk_busy[i] = 1'b1;
                    mk_count++;
                    start = mk_addr[i-1];
                    r.ok  = 1'b1;
                end
            end
            if (!r.ok) begin
                fails_so_far++;
                start = 0;
            end
        end else begin
            for (int i = 1; i < mk_count && !done; i++) begin
                if (mk_addr[i-1] != rq.free_address || !mk_busy[i]) continue;
                done       = 1'b1;
                r.ok       = 1'b1;
                mk_busy[i] = 1'b0;
                j = i;
                // merge with a free segment in front
                if (!mk_busy[i-1]) begin
                    drop_marker(i - 1);
                    j = i - 1;
                end
                // and with a free segment behind
                if (j + 1 < mk_count && !mk_busy[j+1]) drop_marker(j);
            end
        end
        r.address       = start[15:0];
        r.failure_count = fails_so_far;
        return r;
    endfunction

    // ---------------- scoreboard ----------------
    ffa_rsp_t    pending_rsp[$];
    int          mismatches;
    int          rsp_seen;
    int          idle_cycles;
    int          stall_pct;
    int          gap_pct;

    always @(posedge aclk) begin
        ffa_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
                $error("result with no request outstanding: %p", m_data);
                mismatches++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, m_data.ok);
                    mismatches++;
                end
                if (m_data.address !== want.address) begin
                    $error("address: expected %0d, got %0d", want.address, m_data.address);
                    mismatches++;
                end
                if (m_data.failure_count !== want.failure_count) begin
                    $error("failure_count: expected %0d, got %0d",
                           want.failure_count, m_data.failure_count);
                    mismatches++;
                end
            end
        end
    end

    // receiver backpressure, redrawn every cycle
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog: any stretch with no handshake on the request, result or register channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_MAX) begin
                $display("timeout: no handshake for %0d cycles", STALL_MAX);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------- drivers ----------------
    // one request: expectation pushed first, then held until accepted
    task automatic send_request(ffa_req_t rq, bit typed, ffa_rsp_t typed_rsp);
        ffa_rsp_t p;
        p = predict_alloc_free(rq);
        pending_rsp.push_back(typed ? typed_rsp : p);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
        // left high; the next request, a gap or a drain step drives it next
    endtask

    // pool_size write, only once the block has drained
    task automatic write_pool(int unsigned v);
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_rsp.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_units = v & 32'h1FFFF;
        if (pool_units > POOL_MAX) pool_units = POOL_MAX;
        table_reload();
    endtask

    // ---------------- directed table ----------------
    typedef struct {
        bit          is_cfg;
        int unsigned cfg_val;
        ffa_req_t    rq;
        bit          typed;
        ffa_rsp_t    rsp;
    } stim_row_t;

    stim_row_t directed[$];

    function automatic stim_row_t row(bit f, int unsigned sz, int unsigned fa, bit typed = 0,
                                      bit ok = 0, int unsigned ad = 0, int unsigned fc = 0);
        stim_row_t s;
        s.is_cfg = 0;
        s.cfg_val = 0;
        s.rq.func = f;
        s.rq.alloc_size = SIZE_W'(sz);
        s.rq.free_address = FADDR_W'(fa);
        s.typed = typed;
        s.rsp.ok = ok;
        s.rsp.address = RADDR_W'(ad);
        s.rsp.failure_count = fc;
        return s;
    endfunction

    function automatic stim_row_t cfg_row(int unsigned v);
        stim_row_t s;
        s = row(FUNC_ALLOC, 0, 0);
        s.is_cfg  = 1;
        s.cfg_val = v;
        return s;
    endfunction

    // pick the start of a live busy segment, or a random address
    function automatic logic [15:0] pick_free_addr();
        int idx[$];
        for (int i = 1; i < mk_count; i++) if (mk_busy[i]) idx.push_back(i);
        if (idx.size() == 0 || $urandom_range(0, 99) < 20) return 16'($urandom_range(0, 65535));
        return 16'(mk_addr[idx[$urandom_range(0, idx.size() - 1)] - 1]);
    endfunction

    int unsigned pool_plan[8];
    int          sent;

    initial begin
        ffa_req_t rq;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_data = '0;
        m_ready = 1'b0;
        mismatches = 0; rsp_seen = 0; idle_cycles = 0; sent = 0;
        stall_pct = 0; gap_pct = 0;
        pool_units = POOL_MAX;
        fails_so_far = '0;
        table_reload();

        // after reset: whole pool free
        directed.push_back(row(FUNC_ALLOC, 0,      0,     1, 1, 0, 0)); // zero-size at 0
        directed.push_back(row(FUNC_ALLOC, 131071, 0,     1, 0, 0, 1)); // all size bits set
        directed.push_back(row(FUNC_ALLOC, 65536,  0,     1, 1, 0, 1)); // exact fit, full pool
        directed.push_back(row(FUNC_ALLOC, 0,      0));                 // lands at pool end
        directed.push_back(row(FUNC_FREE,  0,      65535, 1, 0, 0, 1)); // no matching segment
        directed.push_back(row(FUNC_FREE,  0,      0));
        directed.push_back(row(FUNC_FREE,  0,      0));
        directed.push_back(row(FUNC_ALLOC, 1,      0));
        directed.push_back(cfg_row(0));                                 // empty pool
        directed.push_back(row(FUNC_ALLOC, 1,      0,     1, 0, 0, 2));
        directed.push_back(row(FUNC_ALLOC, 0,      0,     1, 1, 0, 2));
        directed.push_back(row(FUNC_FREE,  0,      0));
        directed.push_back(cfg_row(32'h1FFFF));                          // capped to 65536
        directed.push_back(row(FUNC_ALLOC, 65536,  0,     1, 1, 0, 2));
        directed.push_back(row(FUNC_ALLOC, 1,      0,     1, 0, 0, 3));
        directed.push_back(cfg_row(1));
        directed.push_back(row(FUNC_ALLOC, 1,      0,     1, 1, 0, 3));
        directed.push_back(row(FUNC_ALLOC, 1,      0,     1, 0, 0, 4));
        directed.push_back(row(FUNC_FREE,  0,      0));
        directed.push_back(row(FUNC_ALLOC, 1,      0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].is_cfg) write_pool(directed[k].cfg_val);
            else send_request(directed[k].rq, directed[k].typed, directed[k].rsp);
        end

        // random phases: each with a pool size and an idling mix
        pool_plan = '{65536, 100, 4096, 1, 300, 65536, 20, 1000};
        for (int ph = 0; ph < 8; ph++) begin
            write_pool(pool_plan[ph]);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 45; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 45; end
                default: begin gap_pct = 7; stall_pct = 7; end
            endcase
            for (int n = 0; n < 62; n++) begin
                rq = '0;
                // a run of allocates opens each phase to build up the table
                if (n < 20 || $urandom_range(0, 99) < 55) begin
                    rq.func = FUNC_ALLOC;
                    if ($urandom_range(0, 99) < 8) begin
                        rq.alloc_size = SIZE_W'($urandom_range(0, 131071));
                    end else begin
                        rq.alloc_size = SIZE_W'($urandom_range(0, pool_units / 16 + 1));
                    end
                    rq.free_address = FADDR_W'($urandom_range(0, 65535));
                end else begin
                    rq.func = FUNC_FREE;
                    rq.alloc_size = SIZE_W'($urandom_range(0, 131071));
                    rq.free_address = pick_free_addr();
                end
                send_request(rq, 0, '0);
                sent++;
            end
        end

        s_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d directed rows and %0d random requests over 8 pool settings",
                 directed.size(), sent);
        $display("%0d results checked, %0d failed allocates counted", rsp_seen, fails_so_far);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ffa_pkg.sv
rtl/ffa_marker_ram.sv
rtl/ffa_cfg.sv
rtl/ffa_engine.sv
rtl/first_fit_allocator.sv
sim/first_fit_allocator_tb.sv
